FILE: rtl/gfbu_pkg.sv
// shared types, constants and the field width table of the frame unpacker
// used by gfbu_ctrl, gfbu_datapath and gsm_frame_bitstream_unpacker_core
package gfbu_pkg;

   localparam int WORD_BITS = 32;
   localparam int CNT_BITS = 6;
   localparam int POS_BITS = 7;
   localparam int VAL_BITS = 7;

   localparam logic [POS_BITS-1:0] NUM_FIELDS = 7'd76;
   localparam logic [POS_BITS-1:0] POS_FLAG = 7'd76;
   localparam logic [POS_BITS-1:0] POS_SILENT = 7'd77;
   localparam logic [POS_BITS-1:0] POS_CODED = 7'd78;
   localparam logic [POS_BITS-1:0] LAST_FIELD = 7'd75;

   localparam logic KIND_CODED = 1'b0;
   localparam logic KIND_SILENT = 1'b1;

   localparam logic [2:0] FIELD_BITS [0:75] = '{
      3'd6, 3'd6, 3'd5, 3'd5, 3'd4, 3'd4, 3'd3, 3'd3,
      3'd7, 3'd2, 3'd2, 3'd6, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3,
      3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3,
      3'd7, 3'd2, 3'd2, 3'd6, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3,
      3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3,
      3'd7, 3'd2, 3'd2, 3'd6, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3,
      3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3,
      3'd7, 3'd2, 3'd2, 3'd6, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3,
      3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3
   };

   typedef struct packed {
      logic load;
      logic step;
      logic flush;
   } cmd_type;

   typedef struct packed {
      logic count_zero;
      logic result_next;
      logic pend_valid;
      logic out_free;
   } status_type;

   typedef struct packed {
      logic kind;
      logic [POS_BITS-1:0] index;
      logic [VAL_BITS-1:0] value;
      logic [4:0] silent;
      logic fend;
   } result_type;

   function automatic logic [2:0] field_width(input logic [POS_BITS-1:0] p);
      logic [2:0] w;
      if (p < NUM_FIELDS) begin
         w = FIELD_BITS[p];
      end else if (p == POS_SILENT) begin
         w = 3'd4;
      end else if (p == POS_CODED) begin
         w = 3'd7;
      end else begin
         w = 3'd1;
      end
      return w;
   endfunction

endpackage

FILE: rtl/gfbu_ctrl.sv
// sequencer of the frame unpacker: word intake, field steps and the final flush
// depends on gfbu_pkg for the command and status structs
module gfbu_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  gfbu_pkg::status_type status,
   output gfbu_pkg::cmd_type    cmd
);
   import gfbu_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_PARSE = 2'd1;
   localparam logic [1:0] ST_FLUSH = 2'd2;

   logic [1:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_PARSE;
            end
         end
         ST_PARSE: begin
            if (status.count_zero) begin
               state_in = ST_FLUSH;
            end else if (!(status.result_next && status.pend_valid && !status.out_free)) begin
               cmd.step = 1'b1;
            end
         end
         ST_FLUSH: begin
            if (!status.pend_valid) begin
               state_in = ST_IDLE;
            end else if (status.out_free) begin
               cmd.flush = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: rtl/gfbu_datapath.sv
// bit buffer, field parser, pending result slot and output register
// depends on gfbu_pkg for the width table, position codes and structs
module gfbu_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  gfbu_pkg::cmd_type    cmd,
   output gfbu_pkg::status_type status,
   input  logic [31:0]          req_stream_word,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_kind,
   output logic [6:0]           rsp_field_index,
   output logic [6:0]           rsp_field_value,
   output logic [4:0]           rsp_silent_frames,
   output logic                 rsp_frame_end,
   output logic                 rsp_word_end
);
   import gfbu_pkg::*;

   logic [WORD_BITS-1:0] shreg_ff, shreg_in;
   logic [CNT_BITS-1:0]  count_ff, count_in;
   logic [POS_BITS-1:0]  pos_ff, pos_in;
   logic [VAL_BITS-1:0]  partial_ff, partial_in;
   logic [2:0]           pc_ff, pc_in;
   logic [7:0]           frames_ff, frames_in;
   logic                 pend_valid_ff, pend_valid_in;
   result_type           pend_ff, pend_in;
   logic                 out_valid_ff, out_valid_in;
   result_type           out_ff, out_in;
   logic                 out_wend_ff, out_wend_in;

   logic [POS_BITS-1:0] p_eff;
   logic [2:0]          need;
   logic [2:0]          take;
   logic [VAL_BITS-1:0] take_mask;
   logic [VAL_BITS-1:0] partial_new;
   logic                complete;
   logic                result_next;
   logic                out_free;
   logic [7:0]          frames_dec;
   result_type          new_res;

   assign p_eff = (pos_ff > POS_CODED) ? POS_FLAG : pos_ff;
   assign need = field_width(p_eff) - pc_ff;
   assign take = (count_ff < {3'b000, need}) ? count_ff[2:0] : need;
   assign take_mask = VAL_BITS'(~(8'hFF << take));
   assign partial_new = partial_ff | VAL_BITS'((shreg_ff[VAL_BITS-1:0] & take_mask) << pc_ff);
   assign complete = (take == need);
   assign result_next = complete && (p_eff != POS_FLAG) && (p_eff != POS_CODED);
   assign out_free = !out_valid_ff || !rsp_stall;
   assign frames_dec = frames_ff - 8'd1;

   assign status.count_zero = (count_ff == '0);
   assign status.result_next = result_next;
   assign status.pend_valid = pend_valid_ff;
   assign status.out_free = out_free;

   always_comb begin
      new_res = '0;
      if (p_eff == POS_SILENT) begin
         new_res.kind = KIND_SILENT;
         new_res.silent = {1'b0, partial_new[3:0]} + 5'd1;
         new_res.fend = 1'b1;
      end else begin
         new_res.kind = KIND_CODED;
         new_res.index = p_eff;
         new_res.value = partial_new;
         new_res.fend = (p_eff == LAST_FIELD);
      end
   end

   always_comb begin
      shreg_in = shreg_ff;
      count_in = count_ff;
      pos_in = pos_ff;
      partial_in = partial_ff;
      pc_in = pc_ff;
      frames_in = frames_ff;
      pend_valid_in = pend_valid_ff;
      pend_in = pend_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      out_in = out_ff;
      out_wend_in = out_wend_ff;

      if (cmd.load) begin
         shreg_in = req_stream_word;
         count_in = CNT_BITS'(WORD_BITS);
      end

      if (cmd.step) begin
         shreg_in = shreg_ff >> take;
         count_in = count_ff - {3'b000, take};
         if (!complete) begin
            partial_in = partial_new;
            pc_in = pc_ff + take;
            pos_in = p_eff;
         end else begin
            partial_in = '0;
            pc_in = '0;
            if (p_eff == POS_FLAG) begin
               pos_in = (partial_new[0]) ? POS_SILENT : POS_CODED;
            end else if (p_eff == POS_SILENT) begin
               pos_in = POS_FLAG;
            end else if (p_eff == POS_CODED) begin
               frames_in = {1'b0, partial_new} + 8'd1;
               pos_in = '0;
            end else if (p_eff == LAST_FIELD) begin
               frames_in = frames_dec;
               pos_in = (frames_dec != '0) ? '0 : POS_FLAG;
            end else begin
               pos_in = p_eff + 7'd1;
            end
            if (result_next) begin
               pend_in = new_res;
               pend_valid_in = 1'b1;
               if (pend_valid_ff) begin
                  out_in = pend_ff;
                  out_wend_in = 1'b0;
                  out_valid_in = 1'b1;
               end
            end
         end
      end

      if (cmd.flush) begin
         out_in = pend_ff;
         out_wend_in = 1'b1;
         out_valid_in = 1'b1;
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         pos_ff <= POS_FLAG;
         partial_ff <= '0;
         pc_ff <= '0;
         frames_ff <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         pos_ff <= pos_in;
         partial_ff <= partial_in;
         pc_ff <= pc_in;
         frames_ff <= frames_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      shreg_ff <= shreg_in;
      pend_ff <= pend_in;
      out_ff <= out_in;
      out_wend_ff <= out_wend_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_kind = out_ff.kind;
   assign rsp_field_index = out_ff.index;
   assign rsp_field_value = out_ff.value;
   assign rsp_silent_frames = out_ff.silent;
   assign rsp_frame_end = out_ff.fend;
   assign rsp_word_end = out_wend_ff;

endmodule

FILE: rtl/gsm_frame_bitstream_unpacker_core.sv
// top level of the gsm full-rate frame unpacker
// depends on gfbu_pkg, gfbu_ctrl and gfbu_datapath
//
// Takes 32-bit stream words, reads them lsb first as one bitstream and gives
// one word per parameter field of each coded frame, or one word per silent
// run carrying its length. Each cycle that parsing is not halted, the parser
// reads one whole field or header item, or the part of it left in the current
// stream word. Around these steps the word is first taken in, then its bits
// are seen to be used up and then its last result is handed over. A new
// stream word is taken only once the previous one is fully parsed. The last
// result of a word is held back one step so that rsp_word_end can be set on
// it; a stalled output register halts parsing only when a further result is
// ready.
module gsm_frame_bitstream_unpacker_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_stream_word,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_kind,
   output logic [6:0]  rsp_field_index,
   output logic [6:0]  rsp_field_value,
   output logic [4:0]  rsp_silent_frames,
   output logic        rsp_frame_end,
   output logic        rsp_word_end
);
   import gfbu_pkg::*;

   cmd_type    cmd;
   status_type status;

   gfbu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   gfbu_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_stream_word   (req_stream_word),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_kind          (rsp_kind),
      .rsp_field_index   (rsp_field_index),
      .rsp_field_value   (rsp_field_value),
      .rsp_silent_frames (rsp_silent_frames),
      .rsp_frame_end     (rsp_frame_end),
      .rsp_word_end      (rsp_word_end)
   );

   a_step_has_bits: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> !status.count_zero)
      else $error("parse step with no bits left");

   a_load_clean: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> !status.pend_valid)
      else $error("new word taken with a result still pending");

   a_flush_free: assert property (@(posedge clock) disable iff (reset)
      cmd.flush |-> (status.out_free && !cmd.step && !cmd.load))
      else $error("flush into a busy output register");

   a_silent_ends_frame: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind) |-> (rsp_frame_end && rsp_silent_frames != 5'd0))
      else $error("silent run result malformed");

endmodule

FILE: tb/tb.sv
// self-checking testbench for gsm_frame_bitstream_unpacker_core
// depends on gfbu_pkg and the unpacker rtl; each rsp word is predicted by a bitwise parser or the directed table
`timescale 1ns / 1ps

module tb;
   import gfbu_pkg::*;

   typedef struct packed {
      logic [6:0] pos;
      logic [6:0] part;
      logic [2:0] pcnt;
      logic [7:0] left;
   } unpacker_state_type;

   typedef struct packed {
      logic       kind;
      logic [6:0] index;
      logic [6:0] value;
      logic [4:0] silent;
      logic       fend;
      logic       wend;
   } field_word_type;

   typedef struct {
      logic [31:0] word;
      int          runs;
      logic [4:0]  run_len;
   } script_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_stream_word = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_kind;
   logic [6:0]  rsp_field_index;
   logic [6:0]  rsp_field_value;
   logic [4:0]  rsp_silent_frames;
   logic        rsp_frame_end;
   logic        rsp_word_end;

   field_word_type     fields_due[$];
   script_row_type     script[$];
   unpacker_state_type pred_st;
   unpacker_state_type gen_st;
   logic [6:0]         gen_target;
   int                 gen_mode;
   int                 idle_pct = 0;
   int                 stall_pct = 0;
   int                 errors = 0;
   int                 words_sent = 0;
   int                 fields_seen = 0;
   int                 runs_seen = 0;
   int                 frames_seen = 0;

   gsm_frame_bitstream_unpacker_core dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_stream_word(req_stream_word),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_kind(rsp_kind),
      .rsp_field_index(rsp_field_index),
      .rsp_field_value(rsp_field_value),
      .rsp_silent_frames(rsp_silent_frames),
      .rsp_frame_end(rsp_frame_end),
      .rsp_word_end(rsp_word_end)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int field_len(input logic [6:0] p);
      int len;
      if (p < 7'd8) begin
         case (p[2:1])
            2'd0: len = 6;
            2'd1: len = 5;
            2'd2: len = 4;
            default: len = 3;
         endcase
      end else if (p < NUM_FIELDS) begin
         case ((int'(p) - 8) % 17)
            0: len = 7;
            1, 2: len = 2;
            3: len = 6;
            default: len = 3;
         endcase
      end else if (p == POS_SILENT) begin
         len = 4;
      end else if (p == POS_CODED) begin
         len = 7;
      end else begin
         len = 1;
      end
      return len;
   endfunction

   function automatic int bits_to_frame_end(input unpacker_state_type s);
      int total;
      total = 0;
      if (s.pos < NUM_FIELDS) begin
         for (int p = int'(s.pos); p < int'(NUM_FIELDS); p++) total += field_len(7'(p));
         total -= int'(s.pcnt);
      end
      return total;
   endfunction

   task automatic parse_bit(inout unpacker_state_type s, input logic b,
                            output logic got, output field_word_type r);
      logic [6:0] p;
      logic [6:0] v;
      got = 1'b0;
      r = '0;
      p = s.pos;
      if (p > POS_CODED) p = POS_FLAG;
      s.part[s.pcnt] = b;
      s.pcnt = s.pcnt + 3'd1;
      s.pos = p;
      if (int'(s.pcnt) >= field_len(p)) begin
         v = s.part;
         s.part = '0;
         s.pcnt = '0;
         if (p == POS_FLAG) begin
            s.pos = v[0] ? POS_SILENT : POS_CODED;
         end else if (p == POS_SILENT) begin
            got = 1'b1;
            r.kind = KIND_SILENT;
            r.silent = {1'b0, v[3:0]} + 5'd1;
            r.fend = 1'b1;
            s.pos = POS_FLAG;
         end else if (p == POS_CODED) begin
            s.left = {1'b0, v} + 8'd1;
            s.pos = '0;
         end else begin
            got = 1'b1;
            r.kind = KIND_CODED;
            r.index = p;
            r.value = v;
            r.fend = (p == LAST_FIELD);
            if (p == LAST_FIELD) begin
               s.left = s.left - 8'd1;
               s.pos = (s.left != 0) ? 7'd0 : POS_FLAG;
            end else begin
               s.pos = p + 7'd1;
            end
         end
      end
   endtask

   task automatic predict_word(input logic [31:0] w, input bit keep);
      logic           got;
      field_word_type r;
      int             n;
      n = 0;
      for (int i = 0; i < 32; i++) begin
         parse_bit(pred_st, w[i], got, r);
         if (got && keep) begin
            fields_due.push_back(r);
            n++;
         end
      end
      if (n > 0) fields_due[$].wend = 1'b1;
   endtask

   task automatic pick_target();
      logic [6:0] p;
      int         len;
      int         roll;
      p = gen_st.pos;
      if (p > POS_CODED) p = POS_FLAG;
      len = field_len(p);
      roll = $urandom_range(99);
      if (p == POS_FLAG) begin
         gen_target = (roll < 35) ? 7'd1 : 7'd0;
      end else if (p == POS_SILENT) begin
         gen_target = 7'($urandom_range(15));
      end else if (p == POS_CODED) begin
         if (roll < 60) gen_target = 7'd0;
         else if (roll < 85) gen_target = 7'd1;
         else if (roll < 95) gen_target = 7'($urandom_range(3, 2));
         else gen_target = 7'($urandom_range(7, 4));
      end else begin
         if (p == 7'd0) gen_mode = (roll < 10) ? 1 : (roll < 20) ? 2 : 0;
         case (gen_mode)
            1: gen_target = 7'd0;
            2: gen_target = 7'((1 << len) - 1);
            default: gen_target = 7'($urandom_range((1 << len) - 1));
         endcase
      end
   endtask

   task automatic make_word(output logic [31:0] w);
      logic           got;
      field_word_type r;
      if (gen_st.pos < NUM_FIELDS && bits_to_frame_end(gen_st) > 32
          && $urandom_range(9) == 0) begin
         w = $urandom;
         for (int i = 0; i < 32; i++) parse_bit(gen_st, w[i], got, r);
         gen_target = 7'($urandom);
      end else begin
         for (int i = 0; i < 32; i++) begin
            if (gen_st.pcnt == 0) pick_target();
            w[i] = gen_target[gen_st.pcnt];
            parse_bit(gen_st, w[i], got, r);
         end
      end
   endtask

   task automatic send_word(input logic [31:0] w);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_stream_word <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      words_sent++;
   endtask

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      field_word_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (fields_due.size() == 0) begin
            $error("rsp word with nothing expected: kind %0d index %0d value %0d",
                   rsp_kind, rsp_field_index, rsp_field_value);
            errors++;
         end else begin
            e = fields_due.pop_front();
            if (rsp_kind !== e.kind) begin
               $error("rsp_kind: expected %0d, got %0d", e.kind, rsp_kind);
               errors++;
            end
            if (rsp_field_index !== e.index) begin
               $error("rsp_field_index: expected %0d, got %0d", e.index, rsp_field_index);
               errors++;
            end
            if (rsp_field_value !== e.value) begin
               $error("rsp_field_value: expected %0d, got %0d", e.value, rsp_field_value);
               errors++;
            end
            if (rsp_silent_frames !== e.silent) begin
               $error("rsp_silent_frames: expected %0d, got %0d", e.silent, rsp_silent_frames);
               errors++;
            end
            if (rsp_frame_end !== e.fend) begin
               $error("rsp_frame_end: expected %0d, got %0d", e.fend, rsp_frame_end);
               errors++;
            end
            if (rsp_word_end !== e.wend) begin
               $error("rsp_word_end: expected %0d, got %0d", e.wend, rsp_word_end);
               errors++;
            end
            if (e.kind == KIND_SILENT) runs_seen++;
            else fields_seen++;
            if (e.kind == KIND_CODED && e.fend) frames_seen++;
         end
      end
   end

   initial begin
      #2_000_000;
      $display("FAILURE");
      $finish;
   end

   initial begin
      field_word_type r;
      logic [31:0]    w;
      pred_st = '{pos: POS_FLAG, part: '0, pcnt: '0, left: '0};
      // all ones from reset: back-to-back silent runs of the longest length
      script.push_back('{32'hFFFF_FFFF, 6, 5'd16});
      script.push_back('{32'hFFFF_FFFF, 6, 5'd16});
      script.push_back('{32'hFFFF_FFFF, 7, 5'd16});
      // shortest silent run, then a single coded frame
      script.push_back('{32'h0000_0000, -1, 5'd0});
      script.push_back('{32'hAAAA_AAAA, -1, 5'd0});
      script.push_back('{32'h5555_5555, -1, 5'd0});
      script.push_back('{32'h8000_0001, -1, 5'd0});
      script.push_back('{32'h7FFF_FFFE, -1, 5'd0});
      script.push_back('{32'h0000_FFFF, -1, 5'd0});
      script.push_back('{32'hFFFF_0000, -1, 5'd0});
      script.push_back('{32'h1234_5678, -1, 5'd0});
      // frame end mid word, silent runs, then another coded frame
      script.push_back('{32'hFFFF_FFFF, -1, 5'd0});
      script.push_back('{32'h0000_0000, -1, 5'd0});
      for (int i = 0; i < 7; i++) script.push_back('{32'hFFFF_FFFF, -1, 5'd0});
      // frame end followed by a two-frame coded run
      script.push_back('{32'h0002_FFFF, -1, 5'd0});

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (script[k]) begin
         if (script[k].runs >= 0) begin
            predict_word(script[k].word, 1'b0);
            for (int j = 0; j < script[k].runs; j++) begin
               r = '0;
               r.kind = KIND_SILENT;
               r.silent = script[k].run_len;
               r.fend = 1'b1;
               r.wend = (j == script[k].runs - 1);
               fields_due.push_back(r);
            end
         end else begin
            predict_word(script[k].word, 1'b1);
         end
         send_word(script[k].word);
      end

      gen_st = pred_st;
      gen_target = 7'($urandom);
      gen_mode = 0;
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 68; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 68; end
            default: begin idle_pct = 25; stall_pct = 25; end
         endcase
         for (int i = 0; i < 48; i++) begin
            make_word(w);
            predict_word(w, 1'b1);
            send_word(w);
         end
      end
      req_valid <= 1'b0;

      while (fields_due.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      $display("%0d stream words sent, %0d of them from the directed table", words_sent,
               script.size());
      $display("%0d coded fields in %0d whole frames and %0d silent runs checked",
               fields_seen, frames_seen, runs_seen);
      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
